// ===== sv/dns_pkg.sv =====
// ----------------------------------------------------------------------------
// dns_pkg
// shared widths, register indexes, shape codes and controller/datapath links
// for the disc neighborhood scanner
// ----------------------------------------------------------------------------
package dns_pkg;

   localparam int COORD_W    = 7;
   localparam int RADIUS_W   = 8;
   localparam int MODE_W     = 2;
   localparam int OFF_W      = 9;    // offset magnitudes
   localparam int BUD_W      = 18;   // signed running budgets
   localparam int COST_W     = 10;   // signed running step costs
   localparam int SBUD_W     = 17;   // budget latched at restart
   localparam int PHASE_W    = 3;
   localparam int POS_W      = OFF_W + 2;  // signed candidate position
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam int DEF_MAP_WIDTH  = 128;
   localparam int DEF_MAP_HEIGHT = 128;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHAPE_MODE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_CENTER = 3'd4;

   // shape modes
   localparam logic [MODE_W-1:0] MODE_BOUND  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POINTY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ROUND  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SQUARE = 2'd3;

   // quadrant phase that moves on to the next offset
   localparam logic [PHASE_W-1:0] PHASE_MOVE = 3'd4;

   typedef struct packed {
      logic init_scan;
      logic step_phase;
      logic step_col;
      logic step_row;
      logic wrap_row;
      logic end_scan;
      logic capture_cell;
      logic capture_done;
      logic load_out;
   } dns_cmd_type;

   typedef struct packed {
      logic active;
      logic phase_move;
      logic phase_skip;
      logic in_map;
      logic col_neg;
      logic row_neg;
      logic out_free;
   } dns_status_type;

endpackage

// ===== sv/dns_ctrl.sv =====
// ----------------------------------------------------------------------------
// dns_ctrl
// sequencer for the scanner: accepts a transaction, walks the datapath
// through mirror candidates and offset moves, hands the result out
// ----------------------------------------------------------------------------
module dns_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_restart,
   output logic                    req_ready,
   input  dns_pkg::dns_status_type sts,
   output dns_pkg::dns_cmd_type    cmd
);
   import dns_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_LOAD = 6'b000010,
      ST_SCAN = 6'b000100,
      ST_MOVE = 6'b001000,
      ST_ROW  = 6'b010000,
      ST_EMIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_restart) begin
                  state_in = ST_LOAD;
               end else if (sts.active) begin
                  state_in = ST_SCAN;
               end else begin
                  cmd.capture_done = 1'b1;
                  state_in         = ST_EMIT;
               end
            end
         end
         ST_LOAD: begin
            cmd.init_scan = 1'b1;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.phase_move) begin
               cmd.step_col = 1'b1;
               state_in     = ST_MOVE;
            end else begin
               cmd.step_phase = 1'b1;
               if (!sts.phase_skip && sts.in_map) begin
                  cmd.capture_cell = 1'b1;
                  state_in         = ST_EMIT;
               end
            end
         end
         ST_MOVE: begin
            if (sts.col_neg) begin
               cmd.step_row = 1'b1;
               state_in     = ST_ROW;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_ROW: begin
            if (sts.row_neg) begin
               cmd.end_scan     = 1'b1;
               cmd.capture_done = 1'b1;
               state_in         = ST_EMIT;
            end else begin
               cmd.wrap_row = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/dns_datapath.sv =====
// ----------------------------------------------------------------------------
// dns_datapath
// configuration registers, scan state (offsets, budgets, costs, phase),
// candidate position and clipping, result hold and output register
// ----------------------------------------------------------------------------
module dns_datapath #(
   parameter int MAP_WIDTH  = dns_pkg::DEF_MAP_WIDTH,
   parameter int MAP_HEIGHT = dns_pkg::DEF_MAP_HEIGHT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [dns_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dns_pkg::CSR_DATA_W-1:0]   csr_data,
   input  dns_pkg::dns_cmd_type             cmd,
   output dns_pkg::dns_status_type          sts,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [dns_pkg::COORD_W-1:0]      rsp_cell_x,
   output logic [dns_pkg::COORD_W-1:0]      rsp_cell_y,
   output logic                             rsp_done_res
);
   import dns_pkg::*;

   // configuration
   logic [COORD_W-1:0]  center_x_ff, center_y_ff;
   logic [RADIUS_W-1:0] radius_ff;
   logic [MODE_W-1:0]   shape_mode_ff;
   logic                skip_center_ff;

   // scan state
   logic [OFF_W-1:0]         offset_x_ff, offset_y_ff;
   logic signed [BUD_W-1:0]  row_budget_ff, col_budget_ff;
   logic signed [COST_W-1:0] row_cost_ff, col_cost_ff;
   logic [PHASE_W-1:0]       phase_ff;
   logic [SBUD_W-1:0]        scan_budget_ff;
   logic                     active_ff;

   // result hold and output register
   logic [COORD_W-1:0] res_x_ff, res_y_ff;
   logic               res_done_ff;
   logic [COORD_W-1:0] out_x_ff, out_y_ff;
   logic               out_done_ff;
   logic               out_valid_ff, out_valid_in;

   logic                     square;
   logic signed [COST_W-1:0] inc, start_cost, col_cost_step, row_cost_step;
   logic [2*RADIUS_W-1:0]    r_sq;
   logic [SBUD_W-1:0]        budget_init;
   logic [POS_W-1:0]         base_x, base_y, off_x, off_y, pos_x, pos_y;
   logic                     x_ok, y_ok;

   assign square     = (shape_mode_ff == MODE_SQUARE);
   assign inc        = square ? COST_W'(0) : COST_W'(2);
   assign start_cost = square ? COST_W'(1) : -COST_W'(1);
   assign col_cost_step = col_cost_ff + inc;
   assign row_cost_step = row_cost_ff + inc;

   // budget taken at restart
   assign r_sq = radius_ff * radius_ff;
   always_comb begin
      case (shape_mode_ff)
         MODE_POINTY: budget_init = {1'b0, r_sq};
         MODE_ROUND:  budget_init = {1'b0, r_sq} + SBUD_W'(1);
         default:     budget_init = {{(SBUD_W-RADIUS_W){1'b0}}, radius_ff};
      endcase
   end

   // mirrored candidate, phase bit 1 negates x and bit 0 negates y
   assign base_x = {{(POS_W-COORD_W){1'b0}}, center_x_ff};
   assign base_y = {{(POS_W-COORD_W){1'b0}}, center_y_ff};
   assign off_x  = {2'b00, offset_x_ff};
   assign off_y  = {2'b00, offset_y_ff};
   assign pos_x  = phase_ff[1] ? base_x - off_x : base_x + off_x;
   assign pos_y  = phase_ff[0] ? base_y - off_y : base_y + off_y;
   assign x_ok   = !pos_x[POS_W-1] && (pos_x[POS_W-2:0] < (POS_W-1)'(MAP_WIDTH));
   assign y_ok   = !pos_y[POS_W-1] && (pos_y[POS_W-2:0] < (POS_W-1)'(MAP_HEIGHT));

   assign sts.active     = active_ff;
   assign sts.phase_move = (phase_ff == PHASE_MOVE);
   assign sts.phase_skip = (phase_ff[1] && (offset_x_ff == '0))
                        || (phase_ff[0] && (offset_y_ff == '0));
   assign sts.in_map     = x_ok && y_ok;
   assign sts.col_neg    = col_budget_ff[BUD_W-1];
   assign sts.row_neg    = row_budget_ff[BUD_W-1];
   assign sts.out_free   = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= '0;
         center_y_ff    <= '0;
         radius_ff      <= '0;
         shape_mode_ff  <= MODE_BOUND;
         skip_center_ff <= 1'b0;
         phase_ff       <= '0;
         active_ff      <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_CENTER_X:    center_x_ff    <= csr_data[COORD_W-1:0];
               CSR_CENTER_Y:    center_y_ff    <= csr_data[COORD_W-1:0];
               CSR_RADIUS:      radius_ff      <= csr_data[RADIUS_W-1:0];
               CSR_SHAPE_MODE:  shape_mode_ff  <= csr_data[MODE_W-1:0];
               CSR_SKIP_CENTER: skip_center_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (cmd.init_scan) begin
            phase_ff  <= skip_center_ff ? PHASE_W'(1) : PHASE_W'(0);
            active_ff <= 1'b1;
         end else if (cmd.step_phase) begin
            phase_ff <= phase_ff + PHASE_W'(1);
         end else if (cmd.step_col) begin
            phase_ff <= '0;
         end
         if (cmd.end_scan) begin
            active_ff <= 1'b0;
         end
      end
   end

   // scan payload
   always_ff @(posedge clock) begin
      if (cmd.init_scan) begin
         scan_budget_ff <= budget_init;
         row_budget_ff  <= {1'b0, budget_init};
         col_budget_ff  <= {1'b0, budget_init};
         row_cost_ff    <= start_cost;
         col_cost_ff    <= start_cost;
         offset_x_ff    <= '0;
         offset_y_ff    <= '0;
      end
      if (cmd.step_col) begin
         offset_x_ff   <= offset_x_ff + OFF_W'(1);
         col_cost_ff   <= col_cost_step;
         col_budget_ff <= col_budget_ff
                          - {{(BUD_W-COST_W){col_cost_step[COST_W-1]}}, col_cost_step};
      end
      if (cmd.step_row) begin
         offset_y_ff   <= offset_y_ff + OFF_W'(1);
         row_cost_ff   <= row_cost_step;
         row_budget_ff <= row_budget_ff
                          - {{(BUD_W-COST_W){row_cost_step[COST_W-1]}}, row_cost_step};
      end
      if (cmd.wrap_row) begin
         offset_x_ff   <= '0;
         col_cost_ff   <= start_cost;
         col_budget_ff <= square ? {1'b0, scan_budget_ff} : row_budget_ff;
      end
      if (cmd.capture_cell) begin
         res_x_ff    <= pos_x[COORD_W-1:0];
         res_y_ff    <= pos_y[COORD_W-1:0];
         res_done_ff <= 1'b0;
      end else if (cmd.capture_done) begin
         res_x_ff    <= '0;
         res_y_ff    <= '0;
         res_done_ff <= 1'b1;
      end
      if (cmd.load_out) begin
         out_x_ff    <= res_x_ff;
         out_y_ff    <= res_y_ff;
         out_done_ff <= res_done_ff;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_cell_x   = out_x_ff;
   assign rsp_cell_y   = out_y_ff;
   assign rsp_done_res = out_done_ff;

endmodule

// ===== sv/disc_neighborhood_scanner.sv =====
// sequence: a restart passes the load state, each mirror candidate is tried in scan,
//   a column move passes move, a row wrap passes row, then emit loads the output register
// throughput: one transaction at a time; the sequencer walks the single candidate/step path
//   one step a cycle, but waits in emit while a held response is not yet taken
// reset: synchronous active high; configuration and phase to zero, scan finished, output empty
// ----------------------------------------------------------------------------
// disc_neighborhood_scanner
// produces, one per transaction, the map cells of a disc or square around
// a configured center, mirrored four ways and clipped to the map
// ----------------------------------------------------------------------------
module disc_neighborhood_scanner #(
   parameter int MAP_WIDTH  = dns_pkg::DEF_MAP_WIDTH,
   parameter int MAP_HEIGHT = dns_pkg::DEF_MAP_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration writes
   input  logic                           csr_write_enable,
   input  logic [dns_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dns_pkg::CSR_DATA_W-1:0] csr_data,
   // request channel: restart or advance
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_restart,
   // response channel: one cell or done per transaction
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [dns_pkg::COORD_W-1:0]    rsp_cell_x,
   output logic [dns_pkg::COORD_W-1:0]    rsp_cell_y,
   output logic                           rsp_done_res
);
   import dns_pkg::*;

   // command and status between sequencer and datapath
   dns_cmd_type    cmd;
   dns_status_type sts;

   // sequencer: idle -> load (restart) -> scan/move/row loop -> emit -> idle
   // an advance with the scan finished goes straight to emit with done set
   dns_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_ready   (req_ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   // datapath: config registers, offsets and budgets, candidate clipping,
   // result hold and the output register that frees the request side
   dns_datapath #(
      .MAP_WIDTH  (MAP_WIDTH),
      .MAP_HEIGHT (MAP_HEIGHT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_cell_x       (rsp_cell_x),
      .rsp_cell_y       (rsp_cell_y),
      .rsp_done_res     (rsp_done_res)
   );

endmodule

// ===== sv/dns_checker.sv =====
// ----------------------------------------------------------------------------
// dns_checker
// port-level checks for the disc neighborhood scanner, bound to the top level
// ----------------------------------------------------------------------------
module dns_checker #(
   parameter int MAP_WIDTH  = dns_pkg::DEF_MAP_WIDTH,
   parameter int MAP_HEIGHT = dns_pkg::DEF_MAP_HEIGHT
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [dns_pkg::COORD_W-1:0] rsp_cell_x,
   input logic [dns_pkg::COORD_W-1:0] rsp_cell_y,
   input logic                        rsp_done_res
);
   import dns_pkg::*;

   // held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_x)
         && $stable(rsp_cell_y) && $stable(rsp_done_res))
      else $error("response changed while stalled");

   // done carries zero coordinates
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_cell_x == '0 && rsp_cell_y == '0)
      else $error("done response with nonzero cell");

   // produced cells lie on the map
   a_on_map: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |->
         ({1'b0, rsp_cell_x} < (COORD_W+1)'(MAP_WIDTH))
         && ({1'b0, rsp_cell_y} < (COORD_W+1)'(MAP_HEIGHT)))
      else $error("cell outside the map");

   // one transaction in flight: ready drops after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while one is in flight");

endmodule

bind disc_neighborhood_scanner dns_checker #(
   .MAP_WIDTH  (MAP_WIDTH),
   .MAP_HEIGHT (MAP_HEIGHT)
) u_dns_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_cell_x   (rsp_cell_x),
   .rsp_cell_y   (rsp_cell_y),
   .rsp_done_res (rsp_done_res)
);

// ===== verif/tb_disc_neighborhood_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_disc_neighborhood_scanner
// self-checking bench for the disc neighborhood scanner: restart and advance
// transactions go in under random idling on both channels, a local scan
// predictor computes each expected cell or done, and every response is
// checked in order against it
// ----------------------------------------------------------------------------
module tb_disc_neighborhood_scanner;
   import dns_pkg::*;

   localparam int LIMIT_CYCLES = 2000000;
   localparam int TAIL_CYCLES  = 20;
   localparam int RANDOM_ITEMS = 400;
   localparam int MAX_REPORTS  = 10;
   localparam int MAP_W        = DEF_MAP_WIDTH;
   localparam int MAP_H        = DEF_MAP_HEIGHT;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               done;
   } scan_cell_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_restart;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [COORD_W-1:0]    rsp_cell_x;
   logic [COORD_W-1:0]    rsp_cell_y;
   logic                  rsp_done_res;

   // shape codes by position, so random picks stay named
   logic [MODE_W-1:0] shape_codes [4] = '{MODE_BOUND, MODE_POINTY, MODE_ROUND, MODE_SQUARE};

   // register mirror, follows every write as it lands
   logic [COORD_W-1:0]  cfg_center_x;
   logic [COORD_W-1:0]  cfg_center_y;
   logic [RADIUS_W-1:0] cfg_radius;
   logic [MODE_W-1:0]   cfg_mode;
   logic                cfg_skip;

   // predicted scan state, plain ints so signed budgets behave naturally
   int off_x, off_y;
   int row_left, col_left;
   int row_step, col_step;
   int mirror;
   int scan_limit;
   bit scanning;

   scan_cell_type expected_cells[$];

   int mismatch_count = 0;
   int responses_seen = 0;
   int cells_seen     = 0;
   int dones_seen     = 0;
   int items_sent     = 0;
   int restarts_sent  = 0;
   int setups_done    = 0;
   int live_writes    = 0;
   int mode_scans [4] = '{0, 0, 0, 0};
   int calm_left      = 0;
   int cycle_count;

   disc_neighborhood_scanner i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_cell_x       (rsp_cell_x),
      .rsp_cell_y       (rsp_cell_y),
      .rsp_done_res     (rsp_done_res)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // scan predictor
   // ------------------------------------------------------------------------

   function automatic void clear_scan_state();
      cfg_center_x = '0;
      cfg_center_y = '0;
      cfg_radius   = '0;
      cfg_mode     = MODE_BOUND;
      cfg_skip     = 1'b0;
      off_x        = 0;
      off_y        = 0;
      row_left     = 0;
      col_left     = 0;
      row_step     = 0;
      col_step     = 0;
      mirror       = 0;
      scan_limit   = 0;
      scanning     = 1'b0;
   endfunction

   // one transaction: restart (optional) then walk to the next on-map cell
   function automatic scan_cell_type next_scan_cell(input logic restart);
      scan_cell_type res;
      int            ph, dx, dy, px, py, step_inc;
      bit            square, found;
      res   = '0;
      found = 1'b0;
      if (restart) begin
         square = (cfg_mode == MODE_SQUARE);
         case (cfg_mode)
            MODE_POINTY: scan_limit = int'(cfg_radius) * int'(cfg_radius);
            MODE_ROUND:  scan_limit = int'(cfg_radius) * int'(cfg_radius) + 1;
            default:     scan_limit = int'(cfg_radius);
         endcase
         off_x    = 0;
         off_y    = 0;
         row_step = square ? 1 : -1;
         col_step = row_step;
         row_left = scan_limit;
         col_left = scan_limit;
         // skipping the center just starts one mirror later
         mirror   = cfg_skip ? 1 : 0;
         scanning = 1'b1;
      end
      while (scanning && !found) begin
         // shape and center are read live, only the budget is latched
         square   = (cfg_mode == MODE_SQUARE);
         step_inc = square ? 0 : 2;
         ph       = mirror;
         if (ph < int'(PHASE_MOVE)) begin
            mirror = ph + 1;
            dx = ((ph & 2) != 0) ? -off_x : off_x;
            dy = ((ph & 1) != 0) ? -off_y : off_y;
            // a negated zero offset would repeat the axis cell
            if (!(((ph & 2) != 0 && off_x == 0) || ((ph & 1) != 0 && off_y == 0))) begin
               px = int'(cfg_center_x) + dx;
               py = int'(cfg_center_y) + dy;
               if (px >= 0 && px < MAP_W && py >= 0 && py < MAP_H) begin
                  res.x = px[COORD_W-1:0];
                  res.y = py[COORD_W-1:0];
                  found = 1'b1;
               end
            end
         end else begin
            mirror    = 0;
            off_x    += 1;
            col_step += step_inc;
            col_left -= col_step;
            if (col_left < 0) begin
               off_y    += 1;
               row_step += step_inc;
               row_left -= row_step;
               if (row_left < 0) begin
                  scanning = 1'b0;
               end else begin
                  off_x    = 0;
                  col_step = square ? 1 : -1;
                  col_left = square ? scan_limit : row_left;
               end
            end
         end
      end
      if (!found) begin
         res.done = 1'b1;
      end
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // idling and drivers
   // ------------------------------------------------------------------------

   // wait draw shared by both channels; every so often a run with no idling
   function automatic int draw_wait();
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm_left = $urandom_range(10, 40);
      end
      return $urandom_range(0, 11);
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endfunction

   // one request transaction; returns whether the predictor expects done
   task automatic send_request(input logic restart, output logic got_done);
      int            gap;
      scan_cell_type pred;
      gap = draw_wait();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      pred = next_scan_cell(restart);
      expected_cells = {expected_cells, pred};
      got_done = pred.done;
      items_sent++;
      if (restart) begin
         restarts_sent++;
         mode_scans[cfg_mode]++;
      end
   endtask

   // drop valid and let every outstanding response drain
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_cells.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= val;
      @(posedge clock);
      case (idx)
         CSR_CENTER_X:    cfg_center_x = val[COORD_W-1:0];
         CSR_CENTER_Y:    cfg_center_y = val[COORD_W-1:0];
         CSR_RADIUS:      cfg_radius   = val[RADIUS_W-1:0];
         CSR_SHAPE_MODE:  cfg_mode     = val[MODE_W-1:0];
         CSR_SKIP_CENTER: cfg_skip     = val[0];
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_scan_config(input int cx, input int cy, input int r,
                                  input logic [MODE_W-1:0] mode, input bit skip);
      wait_idle();
      write_reg(CSR_CENTER_X, CSR_DATA_W'(cx));
      write_reg(CSR_CENTER_Y, CSR_DATA_W'(cy));
      write_reg(CSR_RADIUS, CSR_DATA_W'(r));
      write_reg(CSR_SHAPE_MODE, CSR_DATA_W'(mode));
      write_reg(CSR_SKIP_CENTER, CSR_DATA_W'(skip));
      end_writes();
      setups_done++;
   endtask

   // register change in the middle of a running scan
   task automatic live_update(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      wait_idle();
      write_reg(idx, val);
      end_writes();
      live_writes++;
   endtask

   task automatic advance_n(input int count);
      logic d;
      repeat (count) send_request(1'b0, d);
   endtask

   // advance until the scan reports done, then a few more on the empty scan
   task automatic run_to_done(input int extra);
      logic d;
      d = 1'b0;
      while (!d) send_request(1'b0, d);
      advance_n(extra);
   endtask

   // ------------------------------------------------------------------------
   // response side: random stalls and in-order checking
   // ------------------------------------------------------------------------

   initial begin : rsp_stall
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      scan_cell_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (expected_cells.size() == 0) begin
            note_mismatch($sformatf("response %0d with nothing outstanding: x=%0d y=%0d done=%0b",
                                    responses_seen, rsp_cell_x, rsp_cell_y, rsp_done_res));
         end else begin
            want = expected_cells.pop_front();
            if (rsp_cell_x !== want.x || rsp_cell_y !== want.y || rsp_done_res !== want.done) begin
               note_mismatch($sformatf(
                  "response %0d expected x=%0d y=%0d done=%0b, got x=%0d y=%0d done=%0b",
                  responses_seen, want.x, want.y, want.done,
                  rsp_cell_x, rsp_cell_y, rsp_done_res));
            end
         end
         if (rsp_done_res === 1'b1) begin
            dones_seen++;
         end else begin
            cells_seen++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // directed tests
   // ------------------------------------------------------------------------

   // an advance with no scan ever started reports done
   task automatic test_idle_advance();
      advance_n(1);
   endtask

   // radius zero bound: only the center, then done, and done again
   task automatic test_center_only();
      logic d;
      set_scan_config(0, 0, 0, MODE_BOUND, 1'b0);
      send_request(1'b1, d);
      advance_n(2);
   endtask

   // skipping the center of a zero radius scan leaves nothing at all
   task automatic test_skip_center();
      logic d;
      set_scan_config(0, 0, 0, MODE_BOUND, 1'b1);
      send_request(1'b1, d);
   endtask

   // square at the far corner: three quarters clipped off the map
   task automatic test_corner_square();
      logic d;
      set_scan_config(127, 127, 1, MODE_SQUARE, 1'b0);
      send_request(1'b1, d);
      run_to_done(0);
   endtask

   // pointy disc on the left edge with the center left out
   task automatic test_pointy_edge();
      logic d;
      set_scan_config(0, 127, 1, MODE_POINTY, 1'b1);
      send_request(1'b1, d);
      run_to_done(1);
   endtask

   // widest round disc, then center and shape changed under the running scan
   task automatic test_live_update();
      logic d;
      set_scan_config(64, 64, 255, MODE_ROUND, 1'b0);
      send_request(1'b1, d);
      advance_n(3);
      live_update(CSR_CENTER_X, '0);
      live_update(CSR_CENTER_Y, CSR_DATA_W'(127));
      live_update(CSR_SHAPE_MODE, CSR_DATA_W'(MODE_BOUND));
      advance_n(3);
   endtask

   // ------------------------------------------------------------------------
   // random scans: mostly whole small scans, some long ones cut short,
   // live register changes and restarts over a running scan
   // ------------------------------------------------------------------------

   function automatic int pick_center();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 127;
         default: return $urandom_range(0, 127);
      endcase
   endfunction

   task automatic test_random_scans();
      int                target, r;
      logic [MODE_W-1:0] mode;
      logic              d;
      bit                big;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         // now and then restart again over the same setup
         if (setups_done == 0 || $urandom_range(0, 4) != 0) begin
            mode = shape_codes[$urandom_range(0, 3)];
            if ($urandom_range(0, 7) == 0) begin
               r = ($urandom_range(0, 1) == 0) ? 255 : $urandom_range(100, 255);
            end else if (mode == MODE_BOUND) begin
               r = $urandom_range(0, 20);
            end else if (mode == MODE_SQUARE) begin
               r = $urandom_range(0, 3);
            end else begin
               r = $urandom_range(0, 4);
            end
            set_scan_config(pick_center(), pick_center(), r, mode, bit'($urandom_range(0, 1)));
         end
         big = (cfg_mode == MODE_BOUND) ? (cfg_radius > 20) : (cfg_radius > 4);
         send_request(1'b1, d);
         if (big || $urandom_range(0, 1) == 0) begin
            advance_n($urandom_range(1, 20));
         end else begin
            run_to_done($urandom_range(0, 2));
         end
         // shape changes stay among the disc modes so the scan still ends
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
               0: live_update(CSR_CENTER_X, CSR_DATA_W'(pick_center()));
               1: live_update(CSR_CENTER_Y, CSR_DATA_W'(pick_center()));
               default: begin
                  if (cfg_mode != MODE_SQUARE) begin
                     live_update(CSR_SHAPE_MODE, CSR_DATA_W'(shape_codes[$urandom_range(0, 2)]));
                  end
               end
            endcase
            advance_n($urandom_range(1, 10));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // run control
   // ------------------------------------------------------------------------

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, expected_cells.size());
      $display("FAIL");
      $finish;
   end

   initial begin : main_seq
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_restart      = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      clear_scan_state();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_advance();
      test_center_only();
      test_skip_center();
      test_corner_square();
      test_pointy_edge();
      test_live_update();
      test_random_scans();

      // drain, then give the block time to show any stray response
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_cells.size() != 0) begin
         note_mismatch($sformatf("%0d responses never arrived", expected_cells.size()));
      end

      $display("covered %0d transactions (%0d restarts, %0d setups, %0d live writes)",
               items_sent, restarts_sent, setups_done, live_writes);
      $display("scans by shape bound/pointy/round/square %0d/%0d/%0d/%0d",
               mode_scans[0], mode_scans[1], mode_scans[2], mode_scans[3]);
      $display("cells %0d, done %0d, mismatches %0d",
               cells_seen, dones_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
